### design/bdlp_pkg.sv
// ----------------------------------------------------------------------------
// Button debouncer package
// Shared widths, codes and structures for the debouncer with long-press flags.
// ----------------------------------------------------------------------------
package bdlp_pkg;

  localparam int NUM_BUTTONS = 2;
  localparam int OP_W        = 2;
  localparam int BTN_IDX_W   = 1;
  localparam int TICKS_W     = 16;
  localparam int STATE_W     = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = TICKS_W;

  localparam logic               RST_PRESS_LEVEL = 1'b0;
  localparam logic [TICKS_W-1:0] RST_LONG_TICKS  = TICKS_W'(100);

  typedef enum logic [OP_W-1:0] {
    OP_TICK     = 2'd0,
    OP_WR_SHORT = 2'd1,
    OP_WR_LONG  = 2'd2,
    OP_IDLE     = 2'd3
  } bdlp_op_t;

  typedef enum logic [STATE_W-1:0] {
    ST_RELEASED = 2'd0,
    ST_PRESSED  = 2'd1,
    ST_LONG     = 2'd2
  } bdlp_state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_LEVEL = 2'd0,
    CFG_LONG_TICKS  = 2'd1
  } bdlp_cfg_idx_t;

  typedef struct packed {
    logic [OP_W-1:0]        operation;
    logic [NUM_BUTTONS-1:0] raw_levels;
    logic [BTN_IDX_W-1:0]   button_index;
    logic                   flag_value;
  } bdlp_item_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0]         press_flags;
    logic [NUM_BUTTONS-1:0]         long_press_flags;
    logic [NUM_BUTTONS-1:0]         stable_levels;
    logic [STATE_W*NUM_BUTTONS-1:0] button_states;
  } bdlp_result_t;

  typedef struct packed {
    logic tick;
    logic pressed;
    logic wr_short;
    logic wr_long;
    logic flag_value;
  } bdlp_btn_ctl_t;

  typedef struct packed {
    logic               press_level;
    logic [TICKS_W-1:0] long_press_ticks;
  } bdlp_cfg_t;

endpackage

### design/bdlp_if.sv
// ----------------------------------------------------------------------------
// Button debouncer channels
// Request, result and register-write channels with valid/ready handshakes.
// ----------------------------------------------------------------------------
interface bdlp_in_if
  import bdlp_pkg::*;
();
  logic                   valid;
  logic                   ready;
  logic [OP_W-1:0]        operation;
  logic [NUM_BUTTONS-1:0] raw_levels;
  logic [BTN_IDX_W-1:0]   button_index;
  logic                   flag_value;

  modport source (output valid, operation, raw_levels, button_index, flag_value,
                  input ready);
  modport sink   (input valid, operation, raw_levels, button_index, flag_value,
                  output ready);
endinterface

interface bdlp_out_if
  import bdlp_pkg::*;
();
  logic                           valid;
  logic                           ready;
  logic [NUM_BUTTONS-1:0]         press_flags;
  logic [NUM_BUTTONS-1:0]         long_press_flags;
  logic [NUM_BUTTONS-1:0]         stable_levels;
  logic [STATE_W*NUM_BUTTONS-1:0] button_states;

  modport source (output valid, press_flags, long_press_flags, stable_levels,
                  button_states, input ready);
  modport sink   (input valid, press_flags, long_press_flags, stable_levels,
                  button_states, output ready);
endinterface

interface bdlp_cfg_if
  import bdlp_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

### design/bdlp_cfg.sv
// ----------------------------------------------------------------------------
// Button debouncer configuration registers
// Press level and long-press tick count, written through the register channel.
// ----------------------------------------------------------------------------
module bdlp_cfg
  import bdlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bdlp_cfg_if.sink   cfg_ch,
  output bdlp_cfg_t  cfg
);

  logic               press_level;
  logic [TICKS_W-1:0] long_press_ticks;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      press_level      <= RST_PRESS_LEVEL;
      long_press_ticks <= RST_LONG_TICKS;
    end else if (cfg_ch.valid) begin
      case (cfg_ch.reg_index)
        CFG_PRESS_LEVEL: press_level      <= cfg_ch.wr_data[0];
        CFG_LONG_TICKS:  long_press_ticks <= cfg_ch.wr_data[TICKS_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg.press_level      = press_level;
  assign cfg.long_press_ticks = long_press_ticks;

endmodule

### design/bdlp_sampler.sv
// ----------------------------------------------------------------------------
// Button debouncer sample history
// Three-deep pin history per button and the debounced level it settles on.
// ----------------------------------------------------------------------------
module bdlp_sampler
  import bdlp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tick,
  input  logic [NUM_BUTTONS-1:0] raw,
  output logic [NUM_BUTTONS-1:0] agree,
  output logic [NUM_BUTTONS-1:0] debounced_next
);

  logic [NUM_BUTTONS-1:0] newest_sample;
  logic [NUM_BUTTONS-1:0] middle_sample;
  logic [NUM_BUTTONS-1:0] debounced_level;

  // the oldest sample after the shift is the current middle one
  assign agree = ~(raw ^ newest_sample) & ~(newest_sample ^ middle_sample);

  always_comb begin
    debounced_next = debounced_level;
    if (tick) begin
      debounced_next = (debounced_level & ~agree) | (raw & agree);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_sample   <= {NUM_BUTTONS{RST_PRESS_LEVEL}};
      middle_sample   <= {NUM_BUTTONS{RST_PRESS_LEVEL}};
      debounced_level <= {NUM_BUTTONS{RST_PRESS_LEVEL}};
    end else begin
      if (tick) begin
        newest_sample <= raw;
        middle_sample <= newest_sample;
      end
      debounced_level <= debounced_next;
    end
  end

endmodule

### design/bdlp_button.sv
// ----------------------------------------------------------------------------
// Button debouncer per-button state
// Released / pressed / long-pressed tracking, hold countdown and sticky flags.
// ----------------------------------------------------------------------------
module bdlp_button
  import bdlp_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  bdlp_btn_ctl_t      ctl,
  input  logic [TICKS_W-1:0] long_press_ticks,
  output logic [STATE_W-1:0] state_next_bits,
  output logic               short_next,
  output logic               long_next
);

  bdlp_state_t        state;
  bdlp_state_t        state_next;
  logic [TICKS_W-1:0] countdown;
  logic [TICKS_W-1:0] countdown_next;
  logic [TICKS_W-1:0] countdown_dec;
  logic               short_flag;
  logic               long_flag;

  assign countdown_dec = countdown - TICKS_W'(1);

  always_comb begin
    state_next     = state;
    countdown_next = countdown;
    short_next     = short_flag;
    long_next      = long_flag;
    if (ctl.tick) begin
      case (state)
        ST_RELEASED: begin
          if (ctl.pressed) begin
            state_next     = ST_PRESSED;
            countdown_next = long_press_ticks;
          end
        end
        ST_PRESSED, ST_LONG: begin
          if (ctl.pressed) begin
            if (countdown_dec == '0) begin
              long_next      = 1'b1;
              countdown_next = long_press_ticks;
              state_next     = ST_LONG;
            end else begin
              countdown_next = countdown_dec;
            end
          end else begin
            if (state == ST_PRESSED) begin
              short_next = 1'b1;
            end
            state_next = ST_RELEASED;
          end
        end
        default: ;
      endcase
    end
    if (ctl.wr_short) begin
      short_next = ctl.flag_value;
    end
    if (ctl.wr_long) begin
      long_next = ctl.flag_value;
    end
  end

  assign state_next_bits = state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_RELEASED;
      countdown  <= RST_LONG_TICKS;
      short_flag <= 1'b0;
      long_flag  <= 1'b0;
    end else begin
      state      <= state_next;
      countdown  <= countdown_next;
      short_flag <= short_next;
      long_flag  <= long_next;
    end
  end

endmodule

### design/button_debounce_long_press_core.sv
// ----------------------------------------------------------------------------
// Button debouncer with long-press detection
// Usage:
//   in_ch carries one request per handshake: a sample tick with the raw pin
//   levels, a write of one button's short-press or long-press flag, or idle.
//   out_ch returns exactly one result per request: the flags, debounced
//   levels and button states as they stand after that request.
//   cfg_ch writes the press level (index 0) and the long-press tick count
//   (index 1); it is always ready. Write it only while no request is in
//   flight.
//   A request passes through the request register and then the result register.
//   Throughput is one request per cycle while out_ch does not stall, set by the
//   single update stage between the request register and the result register.
//   Reset clears the flags, puts every button in released, fills the sample
//   history with the reset press level and loads the tick count of 100.
//   When out_ch stalls, the result is held and one more request is taken
//   into the request register; in_ch.ready then drops until out_ch moves.
// ----------------------------------------------------------------------------
module button_debounce_long_press_core
  import bdlp_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  bdlp_in_if.sink    in_ch,
  bdlp_out_if.source out_ch,
  bdlp_cfg_if.sink   cfg_ch
);

  bdlp_cfg_t              cfg;
  logic                   req_valid;
  bdlp_item_t             req;
  logic                   advance;
  logic                   tick;
  logic [NUM_BUTTONS-1:0] agree;
  logic [NUM_BUTTONS-1:0] debounced_next;
  bdlp_btn_ctl_t          btn_ctl [NUM_BUTTONS];
  bdlp_result_t           result_next;
  bdlp_result_t           result;
  logic                   out_valid;

  bdlp_cfg u_cfg (
    .clk    (clk),
    .rst    (rst),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign advance     = req_valid && (!out_valid || out_ch.ready);
  assign in_ch.ready = !req_valid || advance;
  assign tick        = advance && (req.operation == OP_TICK);

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (in_ch.ready) begin
      req_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      req.operation    <= in_ch.operation;
      req.raw_levels   <= in_ch.raw_levels;
      req.button_index <= in_ch.button_index;
      req.flag_value   <= in_ch.flag_value;
    end
  end

  bdlp_sampler u_sampler (
    .clk            (clk),
    .rst            (rst),
    .tick           (tick),
    .raw            (req.raw_levels),
    .agree          (agree),
    .debounced_next (debounced_next)
  );

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_btn
    logic targeted;

    assign targeted = (int'(req.button_index) == b);

    assign btn_ctl[b].tick       = tick && agree[b];
    assign btn_ctl[b].pressed    = (req.raw_levels[b] == cfg.press_level);
    assign btn_ctl[b].wr_short   = advance && (req.operation == OP_WR_SHORT) && targeted;
    assign btn_ctl[b].wr_long    = advance && (req.operation == OP_WR_LONG) && targeted;
    assign btn_ctl[b].flag_value = req.flag_value;

    bdlp_button u_button (
      .clk              (clk),
      .rst              (rst),
      .ctl              (btn_ctl[b]),
      .long_press_ticks (cfg.long_press_ticks),
      .state_next_bits  (result_next.button_states[STATE_W*b +: STATE_W]),
      .short_next       (result_next.press_flags[b]),
      .long_next        (result_next.long_press_flags[b])
    );
  end

  assign result_next.stable_levels = debounced_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      result <= result_next;
    end
  end

  assign out_ch.valid            = out_valid;
  assign out_ch.press_flags      = result.press_flags;
  assign out_ch.long_press_flags = result.long_press_flags;
  assign out_ch.stable_levels    = result.stable_levels;
  assign out_ch.button_states    = result.button_states;

`ifndef SYNTHESIS
  a_no_result_after_reset: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid straight after reset");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (rst)
    !in_ch.ready |-> (req_valid && out_valid && !out_ch.ready))
    else $error("request side stalled without a blocked result");

  a_result_holds_without_advance: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(result))
    else $error("result register changed without an update");

  a_no_undefined_state: assert property (@(posedge clk) disable iff (rst)
    advance |-> (result_next.button_states[STATE_W-1:0] != {STATE_W{1'b1}}))
    else $error("button 0 reached an undefined state");
`endif

endmodule

### verif/bdlp_press_scoreboard.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Debouncer press scoreboard
// Watches the request, result and register-write channels of the button
// debouncer. Keeps its own copy of the sample history, button states, hold
// countdowns and sticky flags, predicts one result per accepted request and
// compares every accepted result field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module bdlp_press_scoreboard
  import bdlp_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  bdlp_in_if          in_ch,
  bdlp_out_if         out_ch,
  bdlp_cfg_if         cfg_ch,
  output int unsigned fault_count,
  output int unsigned results_owed
);

  logic                   press_lvl;
  logic [TICKS_W-1:0]     hold_ticks;
  logic [NUM_BUTTONS-1:0] smp_new;
  logic [NUM_BUTTONS-1:0] smp_mid;
  logic [NUM_BUTTONS-1:0] smp_old;
  logic [NUM_BUTTONS-1:0] debounced;
  bdlp_state_t            btn_state [NUM_BUTTONS];
  logic [TICKS_W-1:0]     countdown [NUM_BUTTONS];
  logic [NUM_BUTTONS-1:0] short_flags;
  logic [NUM_BUTTONS-1:0] long_flags;
  bdlp_result_t           owed_results [$];

  task automatic report_fault(string msg);
    $display("%0t ns: %s", $time, msg);
    fault_count++;
  endtask

  function automatic bdlp_result_t apply_request(bdlp_item_t req);
    logic [NUM_BUTTONS-1:0] agree;
    logic                   held;
    bdlp_result_t           res;
    int                     b;
    case (bdlp_op_t'(req.operation))
      OP_TICK: begin
        smp_old = smp_mid;
        smp_mid = smp_new;
        smp_new = req.raw_levels;
        agree   = ~(smp_new ^ smp_mid) & ~(smp_mid ^ smp_old);
        for (b = 0; b < NUM_BUTTONS; b++) begin
          if (agree[b]) begin
            debounced[b] = smp_new[b];
            held = (smp_new[b] == press_lvl);
            case (btn_state[b])
              ST_RELEASED: begin
                if (held) begin
                  btn_state[b] = ST_PRESSED;
                  countdown[b] = hold_ticks;
                end
              end
              ST_PRESSED, ST_LONG: begin
                if (held) begin
                  countdown[b] = countdown[b] - 1'b1;
                  if (countdown[b] == '0) begin
                    long_flags[b] = 1'b1;
                    countdown[b]  = hold_ticks;
                    btn_state[b]  = ST_LONG;
                  end
                end else begin
                  if (btn_state[b] == ST_PRESSED) short_flags[b] = 1'b1;
                  btn_state[b] = ST_RELEASED;
                end
              end
              default: ;
            endcase
          end
        end
      end
      OP_WR_SHORT: begin
        if (int'(req.button_index) < NUM_BUTTONS) short_flags[req.button_index] = req.flag_value;
      end
      OP_WR_LONG: begin
        if (int'(req.button_index) < NUM_BUTTONS) long_flags[req.button_index] = req.flag_value;
      end
      default: ;
    endcase
    res.press_flags      = short_flags;
    res.long_press_flags = long_flags;
    res.stable_levels    = debounced;
    for (b = 0; b < NUM_BUTTONS; b++) res.button_states[b*STATE_W +: STATE_W] = btn_state[b];
    return res;
  endfunction

  always @(posedge clk) begin : track
    bdlp_item_t   req;
    bdlp_result_t got;
    bdlp_result_t want;
    int           b;
    if (rst) begin
      fault_count = 0;
      press_lvl   = RST_PRESS_LEVEL;
      hold_ticks  = RST_LONG_TICKS;
      smp_new     = {NUM_BUTTONS{RST_PRESS_LEVEL}};
      smp_mid     = smp_new;
      smp_old     = smp_new;
      debounced   = smp_new;
      short_flags = '0;
      long_flags  = '0;
      for (b = 0; b < NUM_BUTTONS; b++) begin
        btn_state[b] = ST_RELEASED;
        countdown[b] = RST_LONG_TICKS;
      end
      owed_results.delete();
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_ch.reg_index)
          CFG_PRESS_LEVEL: press_lvl  = cfg_ch.wr_data[0];
          CFG_LONG_TICKS:  hold_ticks = cfg_ch.wr_data[TICKS_W-1:0];
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        req = '{operation:    in_ch.operation,
                raw_levels:   in_ch.raw_levels,
                button_index: in_ch.button_index,
                flag_value:   in_ch.flag_value};
        owed_results.push_back(apply_request(req));
      end
      if (out_ch.valid && out_ch.ready) begin
        got = '{press_flags:      out_ch.press_flags,
                long_press_flags: out_ch.long_press_flags,
                stable_levels:    out_ch.stable_levels,
                button_states:    out_ch.button_states};
        if (owed_results.size() == 0) begin
          report_fault($sformatf("result with none owed: %h", got));
        end else begin
          want = owed_results.pop_front();
          if (got.press_flags !== want.press_flags)
            report_fault($sformatf("press_flags expected %h got %h",
                                   want.press_flags, got.press_flags));
          if (got.long_press_flags !== want.long_press_flags)
            report_fault($sformatf("long_press_flags expected %h got %h",
                                   want.long_press_flags, got.long_press_flags));
          if (got.stable_levels !== want.stable_levels)
            report_fault($sformatf("stable_levels expected %h got %h",
                                   want.stable_levels, got.stable_levels));
          if (got.button_states !== want.button_states)
            report_fault($sformatf("button_states expected %h got %h",
                                   want.button_states, got.button_states));
        end
      end
    end
    results_owed = owed_results.size();
  end

endmodule

### verif/tb_button_debounce_long_press_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Debouncer with long-press detection testbench
// Drives sample ticks and flag writes into the debouncer under several press
// levels and hold counts: a directed opening, long random runs of bouncy
// press/hold/release sequences, and one steady hold at a zero hold count.
// Both handshake sides idle at random; the scoreboard beside the block
// predicts and compares, and this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_button_debounce_long_press_core;
  import bdlp_pkg::*;

  localparam time         CLK_PERIOD       = 8ns;
  localparam int unsigned RESET_CYCLES     = 6;
  localparam int unsigned SETTLE_CYCLES    = 4;
  localparam int unsigned LONG_HOLD_CYCLES = 300;
  localparam int unsigned WATCHDOG_LIMIT   = 3000;
  localparam int unsigned ZERO_HOLD_TICKS  = 40;
  localparam int          NUM_CFG_REGS     = 2;

  logic clk = 1'b0;
  logic rst;

  bdlp_in_if  in_ch ();
  bdlp_out_if out_ch ();
  bdlp_cfg_if cfg_ch ();

  int unsigned            fault_count;
  int unsigned            results_owed;
  int unsigned            holds_asked = 0;
  int unsigned            tx_calm = 0;
  bit                     tx_idle = 1'b1;
  logic [NUM_BUTTONS-1:0] seg_level = '0;
  int unsigned            seg_left [NUM_BUTTONS];
  int unsigned            stuck_cycles;

  always #(CLK_PERIOD / 2) clk = ~clk;

  button_debounce_long_press_core u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  bdlp_press_scoreboard u_scoreboard (
    .clk          (clk),
    .rst          (rst),
    .in_ch        (in_ch),
    .out_ch       (out_ch),
    .cfg_ch       (cfg_ch),
    .fault_count  (fault_count),
    .results_owed (results_owed)
  );

  function automatic int unsigned gap_cycles();
    return ($urandom_range(0, 99) < 85) ? $urandom_range(1, 3) : $urandom_range(8, 40);
  endfunction

  function automatic bdlp_item_t pack_request(bdlp_op_t op, logic [NUM_BUTTONS-1:0] raw,
                                              logic [BTN_IDX_W-1:0] idx, logic val);
    bdlp_item_t req;
    req.operation    = op;
    req.raw_levels   = raw;
    req.button_index = idx;
    req.flag_value   = val;
    return req;
  endfunction

  task automatic send_request(bdlp_item_t req);
    if (tx_idle && tx_calm == 0 && $urandom_range(0, 99) < 20) begin
      in_ch.valid <= 1'b0;
      repeat (gap_cycles()) @(negedge clk);
    end
    if (tx_calm > 0) tx_calm--;
    else if ($urandom_range(0, 63) == 0) tx_calm = $urandom_range(20, 80);
    in_ch.valid        <= 1'b1;
    in_ch.operation    <= req.operation;
    in_ch.raw_levels   <= req.raw_levels;
    in_ch.button_index <= req.button_index;
    in_ch.flag_value   <= req.flag_value;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic settle();
    in_ch.valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.reg_index <= idx;
    cfg_ch.wr_data   <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic configure(logic level, logic [TICKS_W-1:0] ticks, bit spare);
    logic [CFG_DATA_W-1:0] data;
    int                    i;
    settle();
    data    = CFG_DATA_W'($urandom);
    data[0] = level;
    cfg_write(CFG_PRESS_LEVEL, data);
    cfg_write(CFG_LONG_TICKS, CFG_DATA_W'(ticks));
    if (spare) begin
      for (i = NUM_CFG_REGS; i < (1 << CFG_IDX_W); i++)
        cfg_write(CFG_IDX_W'(i), CFG_DATA_W'($urandom));
    end
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_random_phase(int unsigned n_items, bit ask_long_hold);
    bdlp_item_t  req;
    int unsigned roll;
    int unsigned k;
    int          b;
    for (k = 0; k < n_items; k++) begin
      if (ask_long_hold && k == n_items / 2) holds_asked++;
      roll             = $urandom_range(0, 99);
      req.raw_levels   = NUM_BUTTONS'($urandom);
      req.button_index = BTN_IDX_W'($urandom);
      req.flag_value   = 1'($urandom);
      if (roll < 80) begin
        req.operation = OP_TICK;
        // hold each level for a run of ticks, with the odd bounce on top
        for (b = 0; b < NUM_BUTTONS; b++) begin
          if (seg_left[b] == 0) begin
            seg_level[b] = ~seg_level[b];
            seg_left[b]  = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 6)
                                                      : $urandom_range(6, 40);
          end
          seg_left[b]--;
          req.raw_levels[b] = seg_level[b] ^ ($urandom_range(0, 99) < 6);
        end
      end else if (roll < 90) begin
        req.operation = OP_WR_SHORT;
      end else if (roll < 97) begin
        req.operation = OP_WR_LONG;
      end else begin
        req.operation = OP_IDLE;
      end
      send_request(req);
    end
  endtask

  initial begin : result_sink
    int unsigned stall_left;
    int unsigned calm_left;
    int unsigned holds_done;
    stall_left   = 0;
    calm_left    = 0;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (holds_done != holds_asked) begin
        holds_done++;
        stall_left = LONG_HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
        if (calm_left > 0) calm_left--;
        else if ($urandom_range(0, 63) == 0) calm_left = $urandom_range(20, 120);
        else if ($urandom_range(0, 99) < 15) stall_left = gap_cycles();
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      stuck_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
                 (cfg_ch.valid && cfg_ch.ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned k;
    int          b;
    for (b = 0; b < NUM_BUTTONS; b++) seg_left[b] = 0;
    rst                = 1'b1;
    in_ch.valid        = 1'b0;
    in_ch.operation    = OP_TICK;
    in_ch.raw_levels   = '0;
    in_ch.button_index = '0;
    in_ch.flag_value   = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reg_index   = CFG_PRESS_LEVEL;
    cfg_ch.wr_data     = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    // high level means pressed, two-tick hold count
    configure(1'b1, TICKS_W'(2), 1'b0);
    repeat (7) send_request(pack_request(OP_TICK, 2'b11, 1'b0, 1'b0));
    send_request(pack_request(OP_WR_LONG, 2'b00, 1'b0, 1'b0));
    send_request(pack_request(OP_WR_LONG, 2'b11, 1'b1, 1'b0));
    repeat (3) send_request(pack_request(OP_TICK, 2'b00, 1'b1, 1'b1));
    repeat (3) send_request(pack_request(OP_TICK, 2'b01, 1'b0, 1'b1));
    send_request(pack_request(OP_TICK, 2'b10, 1'b1, 1'b0));
    repeat (3) send_request(pack_request(OP_TICK, 2'b00, 1'b0, 1'b0));
    send_request(pack_request(OP_WR_SHORT, 2'b10, 1'b0, 1'b0));
    send_request(pack_request(OP_WR_SHORT, 2'b01, 1'b1, 1'b1));
    send_request(pack_request(OP_WR_LONG, 2'b11, 1'b1, 1'b1));
    send_request(pack_request(OP_IDLE, NUM_BUTTONS'($urandom), BTN_IDX_W'($urandom),
                              1'($urandom)));
    send_request(pack_request(OP_WR_SHORT, 2'b00, 1'b1, 1'b0));
    send_request(pack_request(OP_TICK, 2'b11, 1'b0, 1'b1));

    configure(1'b0, TICKS_W'(1), 1'b1);
    run_random_phase(150, 1'b1);
    configure(1'b1, '1, 1'b0);
    run_random_phase(120, 1'b0);

    // zero hold count: release, then a steady hold that must not fire early
    configure(1'b0, '0, 1'b0);
    tx_idle = 1'b0;
    repeat (3) send_request(pack_request(OP_TICK, '1, 1'b0, 1'b0));
    for (k = 0; k < ZERO_HOLD_TICKS; k++)
      send_request(pack_request(OP_TICK, '0, 1'b0, 1'b0));
    tx_idle = 1'b1;

    repeat (4) begin
      configure(1'($urandom), TICKS_W'($urandom_range(2, 10)), 1'b0);
      run_random_phase(130, 1'b0);
    end

    settle();
    repeat (2 * SETTLE_CYCLES) @(negedge clk);
    if (fault_count == 0 && results_owed == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
